[src/per_tap_gain_offset_correction_defines.svh]
// ----------------------------------------------------------------------------
// per_tap_gain_offset_correction_defines
// assertion macros shared by the correction block modules
// ----------------------------------------------------------------------------
`ifndef PER_TAP_GAIN_OFFSET_CORRECTION_DEFINES_SVH
`define PER_TAP_GAIN_OFFSET_CORRECTION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PTGO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptgo assertion failed");

// next-cycle implication, checked outside reset
`define PTGO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptgo assertion failed");

`endif

[src/ptgo_pkg.sv]
// ----------------------------------------------------------------------------
// ptgo_pkg
// types and constants of the per-tap gain and offset correction block
// ----------------------------------------------------------------------------
package ptgo_pkg;

    localparam int NUM_AMPS       = 3;
    localparam int AMP_W          = 24;
    localparam int GAIN_W         = 16;
    localparam int DEF_MAX_TAPS_U = 64;
    localparam int DEF_MAX_TAPS_V = 256;

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = 16'sd16384;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CORRECT = 1'b1;

    localparam logic [7:0] CH_U_LOWER = 8'h75;
    localparam logic [7:0] CH_U_UPPER = 8'h55;
    localparam logic [7:0] CH_V_LOWER = 8'h76;
    localparam logic [7:0] CH_V_UPPER = 8'h56;

    localparam logic [2:0] CFG_TAPS_U    = 3'd0;
    localparam logic [2:0] CFG_TAPS_V    = 3'd1;
    localparam logic [2:0] CFG_MIN_TAP_U = 3'd2;
    localparam logic [2:0] CFG_MAX_TAP_U = 3'd3;
    localparam logic [2:0] CFG_MIN_TAP_V = 3'd4;
    localparam logic [2:0] CFG_MAX_TAP_V = 3'd5;

    localparam logic [6:0] RST_TAPS_U    = 7'd64;
    localparam logic [8:0] RST_TAPS_V    = 9'd64;
    localparam logic [5:0] RST_MIN_TAP_U = 6'd0;
    localparam logic [5:0] RST_MAX_TAP_U = 6'd63;
    localparam logic [7:0] RST_MIN_TAP_V = 8'd0;
    localparam logic [7:0] RST_MAX_TAP_V = 8'd63;

    typedef enum logic [2:0] {
        ST_CORRECTED = 3'd0,
        ST_PASSED    = 3'd1,
        ST_WRITTEN   = 3'd2,
        ST_IGNORED   = 3'd3,
        ST_BAD_AXIS  = 3'd4
    } status_t;

    typedef struct packed {
        logic signed [AMP_W-1:0]  offset;
        logic signed [GAIN_W-1:0] gain;
    } coef_t;

    typedef coef_t [NUM_AMPS-1:0] entry_t;

    typedef struct packed {
        status_t status;
        logic    plane;
        logic    corr;
        logic    pass;
    } item_info_t;

endpackage

[src/per_tap_gain_offset_correction.sv]
// ----------------------------------------------------------------------------
// per_tap_gain_offset_correction
// per-tap offset and gain correction of three amplifiers for planes u and v
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while the output does not stall,
// and returns one result for each: the coefficient memory read of the
// addressed plane, the 24x16 multiply of each amplifier lane and the round,
// offset add and saturate step are one register stage each. Loads write the
// memory in the cycle they are accepted, so a correction that follows a load
// of the same tap sees the new entry. A stall on the output holds the whole
// pipeline and drops s_axis_tready. The loaded flags clear at reset at once;
// the coefficient memories need no clearing.
module per_tap_gain_offset_correction #(
    parameter int MAX_TAPS_U = ptgo_pkg::DEF_MAX_TAPS_U,
    parameter int MAX_TAPS_V = ptgo_pkg::DEF_MAX_TAPS_V
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // axis_char, tap, offset1, gain1, offset2, gain2, offset3, gain3,
    // amp_in1, amp_in2, amp_in3
    input  logic [207:0] s_axis_tdata,
    // op
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // amp_out1, amp_out2, amp_out3
    output logic [71:0]  m_axis_tdata,
    // status, plane
    output logic [3:0]   m_axis_tuser,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [8:0]   cfg_wdata
);
    import ptgo_pkg::*;

    localparam int AW_U = (MAX_TAPS_U > 1) ? $clog2(MAX_TAPS_U) : 1;
    localparam int AW_V = (MAX_TAPS_V > 1) ? $clog2(MAX_TAPS_V) : 1;
    localparam logic [8:0] SIZE_U = 9'(MAX_TAPS_U);
    localparam logic [8:0] SIZE_V = 9'(MAX_TAPS_V);

    // configuration
    logic [6:0] taps_u_reg;
    logic [8:0] taps_v_reg;
    logic [5:0] min_tap_u_reg;
    logic [5:0] max_tap_u_reg;
    logic [7:0] min_tap_v_reg;
    logic [7:0] max_tap_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_u_reg    <= RST_TAPS_U;
            taps_v_reg    <= RST_TAPS_V;
            min_tap_u_reg <= RST_MIN_TAP_U;
            max_tap_u_reg <= RST_MAX_TAP_U;
            min_tap_v_reg <= RST_MIN_TAP_V;
            max_tap_v_reg <= RST_MAX_TAP_V;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TAPS_U:    taps_u_reg    <= cfg_wdata[6:0];
                CFG_TAPS_V:    taps_v_reg    <= cfg_wdata;
                CFG_MIN_TAP_U: min_tap_u_reg <= cfg_wdata[5:0];
                CFG_MAX_TAP_U: max_tap_u_reg <= cfg_wdata[5:0];
                CFG_MIN_TAP_V: min_tap_v_reg <= cfg_wdata[7:0];
                CFG_MAX_TAP_V: max_tap_v_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input unpacking
    logic                    in_op;
    logic [7:0]              in_char;
    logic [7:0]              in_tap;
    logic [8:0]              tap9;
    entry_t                  in_entry;
    logic signed [AMP_W-1:0] in_amp [NUM_AMPS];

    assign in_op    = s_axis_tuser[0];
    assign in_char  = s_axis_tdata[7:0];
    assign in_tap   = s_axis_tdata[15:8];
    assign tap9     = {1'b0, in_tap};

    always_comb
    begin
        for (int k = 0; k < NUM_AMPS; k++)
        begin
            in_entry[k].offset = s_axis_tdata[16 + 40*k +: AMP_W];
            in_entry[k].gain   = s_axis_tdata[40 + 40*k +: GAIN_W];
            in_amp[k]          = s_axis_tdata[136 + AMP_W*k +: AMP_W];
        end
    end

    // pipeline control
    logic v1_reg, v2_reg, v3_reg;
    logic en;
    logic accept;

    assign en            = !v3_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid && en;

    // decode
    logic       is_u, is_v;
    logic       cnt_ok_u, cnt_ok_v;
    logic       win_u, win_v;
    logic       cnt_ok, win;
    item_info_t info_next;
    logic       we_u, we_v, re;

    always_comb
    begin
        is_u     = (in_char == CH_U_LOWER) || (in_char == CH_U_UPPER);
        is_v     = (in_char == CH_V_LOWER) || (in_char == CH_V_UPPER);
        cnt_ok_u = (tap9 < SIZE_U) && (tap9 < {2'b00, taps_u_reg});
        cnt_ok_v = (tap9 < SIZE_V) && (tap9 < taps_v_reg);
        win_u    = (in_tap >= {2'b00, min_tap_u_reg}) && (in_tap <= {2'b00, max_tap_u_reg});
        win_v    = (in_tap >= min_tap_v_reg) && (in_tap <= max_tap_v_reg);
        cnt_ok   = is_v ? cnt_ok_v : cnt_ok_u;
        win      = is_v ? win_v : win_u;

        info_next.plane = is_v;
        info_next.corr  = 1'b0;
        info_next.pass  = 1'b0;
        if (!is_u && !is_v)
        begin
            info_next.status = ST_BAD_AXIS;
            info_next.pass   = (in_op == OP_CORRECT);
        end
        else if (in_op == OP_LOAD)
        begin
            info_next.status = cnt_ok ? ST_WRITTEN : ST_IGNORED;
        end
        else if (cnt_ok && win)
        begin
            info_next.status = ST_CORRECTED;
            info_next.corr   = 1'b1;
        end
        else
        begin
            info_next.status = ST_PASSED;
            info_next.pass   = 1'b1;
        end

        we_u = accept && (in_op == OP_LOAD) && is_u && cnt_ok_u;
        we_v = accept && (in_op == OP_LOAD) && is_v && cnt_ok_v;
        re   = accept && (in_op == OP_CORRECT);
    end

    // coefficient memories
    entry_t u_rdata, v_rdata;
    logic   u_loaded, v_loaded;

    ptgo_table #(
        .DEPTH (MAX_TAPS_U),
        .AW    (AW_U)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (we_u),
        .re     (re),
        .addr   (in_tap[AW_U-1:0]),
        .wdata  (in_entry),
        .rdata  (u_rdata),
        .loaded (u_loaded)
    );

    ptgo_table #(
        .DEPTH (MAX_TAPS_V),
        .AW    (AW_V)
    ) v_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .we     (we_v),
        .re     (re),
        .addr   (in_tap[AW_V-1:0]),
        .wdata  (in_entry),
        .rdata  (v_rdata),
        .loaded (v_loaded)
    );

    // stage 1: memory data arrives with the item
    item_info_t              info1_reg, info2_reg, info3_reg;
    logic signed [AMP_W-1:0] amp1_reg [NUM_AMPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            info1_reg <= info_next;
            info2_reg <= info1_reg;
            info3_reg <= info2_reg;
            for (int k = 0; k < NUM_AMPS; k++)
            begin
                amp1_reg[k] <= in_amp[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // pass-through and unloaded taps run the lane with unit gain, loads zero gain
    entry_t sel_entry;
    logic   sel_loaded;
    logic signed [AMP_W-1:0]  lane_p [NUM_AMPS];
    logic signed [GAIN_W-1:0] lane_q [NUM_AMPS];
    logic signed [AMP_W-1:0]  lane_res [NUM_AMPS];

    always_comb
    begin
        sel_entry  = info1_reg.plane ? v_rdata : u_rdata;
        sel_loaded = info1_reg.plane ? v_loaded : u_loaded;
        for (int k = 0; k < NUM_AMPS; k++)
        begin
            if (info1_reg.corr && sel_loaded)
            begin
                lane_p[k] = sel_entry[k].offset;
                lane_q[k] = sel_entry[k].gain;
            end
            else
            begin
                lane_p[k] = '0;
                lane_q[k] = (info1_reg.corr || info1_reg.pass) ? GAIN_ONE : '0;
            end
        end
    end

    for (genvar g = 0; g < NUM_AMPS; g++)
    begin : g_lane
        ptgo_mac u_mac (
            .clk (clk),
            .en  (en),
            .p   (lane_p[g]),
            .q   (lane_q[g]),
            .amp (amp1_reg[g]),
            .res (lane_res[g])
        );
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {lane_res[2], lane_res[1], lane_res[0]};
    assign m_axis_tuser  = {info3_reg.plane, info3_reg.status};

`include "per_tap_gain_offset_correction_defines.svh"

    `PTGO_ASSERT_NOW(a_valid_follows_stage, $rose(v3_reg), $past(v2_reg))
    `PTGO_ASSERT_NOW(a_load_result_zero, v3_reg && info3_reg.status == ST_WRITTEN, m_axis_tdata == '0)
    `PTGO_ASSERT_NOW(a_bad_axis_plane_u, v3_reg && info3_reg.status == ST_BAD_AXIS, !info3_reg.plane)

endmodule

[src/ptgo_table.sv]
// ----------------------------------------------------------------------------
// ptgo_table
// coefficient memory of one plane with per-tap loaded flags
// ----------------------------------------------------------------------------
module ptgo_table #(
    parameter int DEPTH = ptgo_pkg::DEF_MAX_TAPS_U,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  ptgo_pkg::entry_t wdata,
    output ptgo_pkg::entry_t rdata,
    output logic             loaded
);
    import ptgo_pkg::*;

    entry_t           mem [DEPTH];
    entry_t           rdata_reg;
    logic             loaded_reg;
    logic [DEPTH-1:0] loaded_bits_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_bits_reg <= '0;
            loaded_reg      <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                loaded_bits_reg[addr] <= 1'b1;
            end
            if (re)
            begin
                loaded_reg <= loaded_bits_reg[addr];
            end
        end
    end

    assign rdata  = rdata_reg;
    assign loaded = loaded_reg;

`include "per_tap_gain_offset_correction_defines.svh"

    `PTGO_ASSERT_NEXT(a_load_marks_entry, we, loaded_bits_reg[$past(addr)])

endmodule

[src/ptgo_mac.sv]
// ----------------------------------------------------------------------------
// ptgo_mac
// one amplifier lane: multiply, then round, add offset and saturate
// ----------------------------------------------------------------------------
module ptgo_mac (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ptgo_pkg::AMP_W-1:0]  p,
    input  logic signed [ptgo_pkg::GAIN_W-1:0] q,
    input  logic signed [ptgo_pkg::AMP_W-1:0]  amp,
    output logic signed [ptgo_pkg::AMP_W-1:0]  res
);
    import ptgo_pkg::*;

    localparam int PROD_W = AMP_W + GAIN_W;
    localparam int RND_W  = PROD_W - 14;
    localparam int SUM_W  = RND_W + 1;

    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(8192);
    localparam logic signed [SUM_W-1:0]  SAT_MAX  = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0]  SAT_MIN  = -SUM_W'(8388608);

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [AMP_W-1:0]  p_reg;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [RND_W-1:0]  rnd;
    logic signed [SUM_W-1:0]  sum;
    logic signed [AMP_W-1:0]  res_reg;
    logic signed [AMP_W-1:0]  res_next;

    assign prod_next = q * amp;

    // round half up at the Q.14 point, add the offset, then saturate to 24 bits
    always_comb
    begin
        prod_rnd = prod_reg + RND_HALF;
        rnd      = RND_W'(prod_rnd >>> 14);
        sum      = SUM_W'(p_reg) + SUM_W'(rnd);
        if (sum > SAT_MAX)
        begin
            res_next = AMP_W'(SAT_MAX);
        end
        else if (sum < SAT_MIN)
        begin
            res_next = AMP_W'(SAT_MIN);
        end
        else
        begin
            res_next = AMP_W'(sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            p_reg    <= p;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

[dv/per_tap_gain_offset_correction_tb.sv]
// ----------------------------------------------------------------------------
// per_tap_gain_offset_correction_tb
// self-checking bench for the per-tap gain and offset correction block
// ----------------------------------------------------------------------------
// Loads and corrections are fed through the input stream. A software copy of
// the coefficient tables and window registers predicts every result in order
// of acceptance. Each output transaction is compared field by field. The run
// goes through several register settings and through phases with and without
// random idling on the input side and random stalls on the output side.
module per_tap_gain_offset_correction_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ptgo_pkg::*;

    localparam logic [AMP_W-1:0]  AMP_POS_FULL  = 24'h7FFFFF;
    localparam logic [AMP_W-1:0]  AMP_NEG_FULL  = 24'h800000;
    localparam logic [GAIN_W-1:0] GAIN_POS_FULL = 16'h7FFF;
    localparam logic [GAIN_W-1:0] GAIN_NEG_FULL = 16'h8000;
    localparam longint            SAT_HI        = 64'sd8388607;
    localparam longint            SAT_LO        = -64'sd8388608;
    // index past the register list, must be ignored
    localparam logic [2:0]        CFG_SPARE     = 3'd7;

    typedef struct packed {
        logic                            op;
        logic [7:0]                      axis_char;
        logic [7:0]                      tap;
        logic [NUM_AMPS-1:0][AMP_W-1:0]  offs;
        logic [NUM_AMPS-1:0][GAIN_W-1:0] gains;
        logic [NUM_AMPS-1:0][AMP_W-1:0]  amps;
    } event_item_t;

    typedef struct packed {
        status_t                        status;
        logic                           plane;
        logic [NUM_AMPS-1:0][AMP_W-1:0] amps;
    } corr_result_t;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // axis_char, tap, offset1, gain1, offset2, gain2, offset3, gain3,
    // amp_in1, amp_in2, amp_in3
    logic [207:0] s_axis_tdata  = '0;
    // op
    logic [0:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // amp_out1, amp_out2, amp_out3
    logic [71:0]  m_axis_tdata;
    // status, plane
    logic [3:0]   m_axis_tuser;
    logic         cfg_we        = 1'b0;
    logic [2:0]   cfg_addr      = '0;
    logic [8:0]   cfg_wdata     = '0;

    per_tap_gain_offset_correction dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the block's registers and coefficient tables
    logic [6:0]   cfg_taps_u    = RST_TAPS_U;
    logic [8:0]   cfg_taps_v    = RST_TAPS_V;
    logic [5:0]   cfg_min_tap_u = RST_MIN_TAP_U;
    logic [5:0]   cfg_max_tap_u = RST_MAX_TAP_U;
    logic [7:0]   cfg_min_tap_v = RST_MIN_TAP_V;
    logic [7:0]   cfg_max_tap_v = RST_MAX_TAP_V;
    entry_t       u_table  [DEF_MAX_TAPS_U];
    entry_t       v_table  [DEF_MAX_TAPS_V];
    bit           u_loaded [DEF_MAX_TAPS_U];
    bit           v_loaded [DEF_MAX_TAPS_V];

    event_item_t  pending_events_q[$];
    corr_result_t expected_results_q[$];
    event_item_t  drive_event;
    int unsigned  send_idle_pct  = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  mismatch_count = 0;

    // offset + round(gain * amp), saturated to a signed 24-bit integer (Q23.0)
    function automatic logic [AMP_W-1:0] mac_sat(logic [AMP_W-1:0] p, logic [GAIN_W-1:0] q,
                                                 logic [AMP_W-1:0] a);
        longint prod;
        longint sum;
        prod = longint'($signed(q)) * longint'($signed(a));
        sum  = longint'($signed(p)) + ((prod + 64'sd8192) >>> 14);
        if (sum > SAT_HI)
            sum = SAT_HI;
        if (sum < SAT_LO)
            sum = SAT_LO;
        return sum[AMP_W-1:0];
    endfunction

    function automatic corr_result_t predict_correction(event_item_t ev);
        corr_result_t res;
        entry_t       e;
        logic         is_u;
        logic         is_v;
        bit           was_loaded;
        int unsigned  tap;
        int unsigned  cnt;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  size;
        res.status = ST_BAD_AXIS;
        res.plane  = 1'b0;
        res.amps   = '0;
        tap  = ev.tap;
        is_u = (ev.axis_char == CH_U_LOWER) || (ev.axis_char == CH_U_UPPER);
        is_v = (ev.axis_char == CH_V_LOWER) || (ev.axis_char == CH_V_UPPER);
        if (!is_u && !is_v)
        begin
            if (ev.op == OP_CORRECT)
                res.amps = ev.amps;
            return res;
        end
        res.plane = is_v;
        if (is_v)
        begin
            cnt  = cfg_taps_v;
            lo   = cfg_min_tap_v;
            hi   = cfg_max_tap_v;
            size = DEF_MAX_TAPS_V;
        end
        else
        begin
            cnt  = cfg_taps_u;
            lo   = cfg_min_tap_u;
            hi   = cfg_max_tap_u;
            size = DEF_MAX_TAPS_U;
        end
        if (cnt > size)
            cnt = size;
        if (ev.op == OP_LOAD)
        begin
            if (tap < cnt)
            begin
                for (int k = 0; k < NUM_AMPS; k++)
                begin
                    e[k].offset = ev.offs[k];
                    e[k].gain   = ev.gains[k];
                end
                if (is_v)
                begin
                    v_table[tap]  = e;
                    v_loaded[tap] = 1'b1;
                end
                else
                begin
                    u_table[tap]  = e;
                    u_loaded[tap] = 1'b1;
                end
                res.status = ST_WRITTEN;
            end
            else
                res.status = ST_IGNORED;
        end
        else if (tap >= lo && tap <= hi && tap < cnt)
        begin
            was_loaded = is_v ? v_loaded[tap] : u_loaded[tap];
            if (was_loaded)
                e = is_v ? v_table[tap] : u_table[tap];
            else
                for (int k = 0; k < NUM_AMPS; k++)
                begin
                    e[k].offset = '0;
                    e[k].gain   = GAIN_ONE;
                end
            for (int k = 0; k < NUM_AMPS; k++)
                res.amps[k] = mac_sat(e[k].offset, e[k].gain, ev.amps[k]);
            res.status = ST_CORRECTED;
        end
        else
        begin
            res.amps   = ev.amps;
            res.status = ST_PASSED;
        end
        return res;
    endfunction

    // input side: holds tvalid until accepted, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results_q.push_back(predict_correction(drive_event));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_events_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    drive_event = pending_events_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= drive_event.op;
                    s_axis_tdata  <= {drive_event.amps[2], drive_event.amps[1],
                                      drive_event.amps[0],
                                      drive_event.gains[2], drive_event.offs[2],
                                      drive_event.gains[1], drive_event.offs[1],
                                      drive_event.gains[0], drive_event.offs[0],
                                      drive_event.tap, drive_event.axis_char};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side: random stalls and in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        corr_result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results_q.size() == 0)
                begin
                    $error("output transaction with no expected result pending");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results_q.pop_front();
                    if (m_axis_tuser[2:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tuser[2:0]);
                        mismatch_count++;
                    end
                    if (m_axis_tuser[3] !== want.plane)
                    begin
                        $error("plane: expected %0d, got %0d", want.plane, m_axis_tuser[3]);
                        mismatch_count++;
                    end
                    for (int k = 0; k < NUM_AMPS; k++)
                        if (m_axis_tdata[k*AMP_W +: AMP_W] !== want.amps[k])
                        begin
                            $error("amp_out%0d: expected %h, got %h", k + 1, want.amps[k],
                                   m_axis_tdata[k*AMP_W +: AMP_W]);
                            mismatch_count++;
                        end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [AMP_W-1:0] rand_amp_value();
        case ($urandom_range(19))
            0:       return AMP_POS_FULL;
            1:       return AMP_NEG_FULL;
            2:       return '0;
            3:       return '1;
            4, 5, 6: return AMP_W'($signed(12'($urandom)));
            default: return AMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] rand_gain_value();
        case ($urandom_range(9))
            0:       return GAIN_POS_FULL;
            1:       return GAIN_NEG_FULL;
            2, 3, 4: return GAIN_ONE + GAIN_W'($urandom_range(511)) - GAIN_W'(256);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // taps cluster at low entries and at the window and count edges
    function automatic logic [7:0] pick_tap(logic v_plane);
        int unsigned cnt;
        int unsigned lo;
        int unsigned hi;
        cnt = v_plane ? cfg_taps_v : cfg_taps_u;
        lo  = v_plane ? cfg_min_tap_v : cfg_min_tap_u;
        hi  = v_plane ? cfg_max_tap_v : cfg_max_tap_u;
        if (!v_plane && cnt > DEF_MAX_TAPS_U)
            cnt = DEF_MAX_TAPS_U;
        if (v_plane && cnt > DEF_MAX_TAPS_V)
            cnt = DEF_MAX_TAPS_V;
        case ($urandom_range(9))
            0, 1, 2, 3: return 8'($urandom_range(15));
            4, 5:       return 8'($urandom);
            6:          return 8'(lo + $urandom_range(2) - 1);
            7:          return 8'(hi + $urandom_range(2) - 1);
            default:    return 8'(cnt + $urandom_range(1) - 1);
        endcase
    endfunction

    function automatic event_item_t rand_event();
        event_item_t ev;
        int unsigned sel;
        sel    = $urandom_range(99);
        ev.op  = ($urandom_range(99) < 40) ? OP_LOAD : OP_CORRECT;
        if (sel < 10)
            ev.axis_char = 8'($urandom);
        else
            case (sel % 4)
                0:       ev.axis_char = CH_U_LOWER;
                1:       ev.axis_char = CH_U_UPPER;
                2:       ev.axis_char = CH_V_LOWER;
                default: ev.axis_char = CH_V_UPPER;
            endcase
        ev.tap = pick_tap(ev.axis_char == CH_V_LOWER || ev.axis_char == CH_V_UPPER);
        for (int k = 0; k < NUM_AMPS; k++)
        begin
            ev.offs[k]  = rand_amp_value();
            ev.gains[k] = rand_gain_value();
            ev.amps[k]  = rand_amp_value();
        end
        return ev;
    endfunction

    task automatic push_load(logic [7:0] ch, logic [7:0] tap,
                             logic [NUM_AMPS-1:0][AMP_W-1:0] offs,
                             logic [NUM_AMPS-1:0][GAIN_W-1:0] gains);
        event_item_t ev;
        ev           = rand_event();
        ev.op        = OP_LOAD;
        ev.axis_char = ch;
        ev.tap       = tap;
        ev.offs      = offs;
        ev.gains     = gains;
        pending_events_q.push_back(ev);
    endtask

    task automatic push_correct(logic [7:0] ch, logic [7:0] tap,
                                logic [NUM_AMPS-1:0][AMP_W-1:0] amps);
        event_item_t ev;
        ev           = rand_event();
        ev.op        = OP_CORRECT;
        ev.axis_char = ch;
        ev.tap       = tap;
        ev.amps      = amps;
        pending_events_q.push_back(ev);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TAPS_U:    cfg_taps_u    = val[6:0];
            CFG_TAPS_V:    cfg_taps_v    = val[8:0];
            CFG_MIN_TAP_U: cfg_min_tap_u = val[5:0];
            CFG_MAX_TAP_U: cfg_max_tap_u = val[5:0];
            CFG_MIN_TAP_V: cfg_min_tap_v = val[7:0];
            CFG_MAX_TAP_V: cfg_max_tap_v = val[7:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int unsigned tu, int unsigned tv, int unsigned lou,
                            int unsigned hiu, int unsigned lov, int unsigned hiv);
        write_reg(CFG_TAPS_U, 9'(tu));
        write_reg(CFG_TAPS_V, 9'(tv));
        write_reg(CFG_MIN_TAP_U, 9'(lou));
        write_reg(CFG_MAX_TAP_U, 9'(hiu));
        write_reg(CFG_MIN_TAP_V, 9'(lov));
        write_reg(CFG_MAX_TAP_V, 9'(hiv));
    endtask

    task automatic set_pace(int unsigned mode);
        case (mode)
            1:
            begin
                send_idle_pct  = 83;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 83;
            end
            3:
            begin
                send_idle_pct  = 21;
                recv_stall_pct = 21;
            end
            default:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // waits until every event is sent and every result is back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_events_q.size() != 0 || s_axis_tvalid ||
               expected_results_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_pace(0);

        // unloaded taps reproduce the input exactly
        push_correct(CH_U_LOWER, 8'd0, {24'd0, AMP_NEG_FULL, AMP_POS_FULL});
        push_correct(CH_U_UPPER, 8'd63, {24'd123456, 24'd1, 24'hFFFFFF});
        // full-scale coefficients drive the sum into saturation
        push_load(CH_U_LOWER, 8'd5, {24'd0, AMP_NEG_FULL, AMP_POS_FULL},
                  {GAIN_ONE, GAIN_NEG_FULL, GAIN_POS_FULL});
        push_correct(CH_U_LOWER, 8'd5, {AMP_NEG_FULL, AMP_POS_FULL, AMP_POS_FULL});
        push_correct(CH_U_UPPER, 8'd5, {AMP_POS_FULL, AMP_NEG_FULL, AMP_NEG_FULL});
        // rounding exactly at one half, both signs
        push_load(CH_V_UPPER, 8'd0, '0, {16'd3, 16'hFFFF, 16'd1});
        push_correct(CH_V_LOWER, 8'd0, {-24'sd8192, 24'd8192, 24'd8192});
        push_correct(CH_V_UPPER, 8'd0, {24'd24576, -24'sd24576, -24'sd8192});
        push_load(CH_U_LOWER, 8'd63, {24'd1, -24'sd256, 24'd256},
                  {-16'sd16384, 16'd8192, GAIN_ONE});
        push_correct(CH_U_LOWER, 8'd63, {24'h0ABCDE, 24'hF00001, 24'd12345});
        // loads at or beyond the tap count
        push_load(CH_U_LOWER, 8'd64, '1, '1);
        push_load(CH_V_LOWER, 8'd64, '1, '1);
        push_load(CH_V_UPPER, 8'd255, '1, '1);
        push_correct(CH_U_LOWER, 8'd64, {24'd3, 24'd2, 24'd1});
        // outside the window
        push_correct(CH_V_LOWER, 8'd64, {24'd7, 24'd6, 24'd5});
        push_correct(CH_U_UPPER, 8'd200, {AMP_POS_FULL, 24'd0, AMP_NEG_FULL});
        // bad plane letters, then further loads and corrections on valid planes
        push_correct(8'h00, 8'd5, {24'h123456, 24'hFEDCBA, AMP_NEG_FULL});
        push_load(8'hFF, 8'd5, '1, '1);
        push_correct(8'h77, 8'd0, {24'd9, 24'd8, 24'd7});
        push_load(8'h57, 8'd1, '1, '1);
        push_correct(CH_U_LOWER, 8'd5, {24'd100, 24'd100, 24'd100});
        push_load(CH_V_LOWER, 8'd63, {AMP_NEG_FULL, 24'd0, AMP_POS_FULL},
                  {GAIN_POS_FULL, 16'd0, GAIN_NEG_FULL});
        push_correct(CH_V_UPPER, 8'd63, {24'hFFFFFF, 24'h7FFFFF, 24'h800000});
        repeat (150) pending_events_q.push_back(rand_event());
        wait_drained();

        for (int ph = 1; ph <= 7; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(CFG_SPARE, 9'h1FF);
                    // counts above the table sizes are clipped
                    set_regs(127, 511, 0, 63, 0, 255);
                end
                2: set_regs(0, 0, 0, 63, 0, 255);
                3: set_regs(32, 200, 10, 40, 50, 220);
                // min above max leaves the window empty
                4: set_regs(64, 256, 63, 0, 255, 0);
                5: set_regs(64, 256, 7, 7, 128, 128);
                default: set_regs($urandom_range(127), $urandom_range(511), $urandom_range(63),
                                  $urandom_range(63), $urandom_range(255), $urandom_range(255));
            endcase
            set_pace(ph % 4);
            @(negedge clk);
            repeat (168) pending_events_q.push_back(rand_event());
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/ptgo_pkg.sv
src/ptgo_table.sv
src/ptgo_mac.sv
src/per_tap_gain_offset_correction.sv
dv/per_tap_gain_offset_correction_tb.sv
